[design/drt_pkg.sv]
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants for the delayed repeat timer controller.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 16;
	localparam int COUNT_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD_TICKS      = 3'd0,
		CFG_START_DELAY_TICKS = 3'd1,
		CFG_DURATION_TICKS    = 3'd2,
		CFG_REPEAT_LIMIT      = 3'd3,
		CFG_COUNT_PAST_LIMIT  = 3'd4,
		CFG_ONESHOT_MODE      = 3'd5,
		CFG_TIMERS_PRESENT    = 3'd6,
		CFG_TASK_ENABLED      = 3'd7
	} cfg_idx_t;

	// one-shot event selections
	typedef enum logic [2:0] {
		OS_START         = 3'd0,
		OS_RUN           = 3'd1,
		OS_START_RUN     = 3'd2,
		OS_START_RUN_END = 3'd3,
		OS_START_END     = 3'd4,
		OS_RUN_END       = 3'd5,
		OS_NONE          = 3'd6
	} oneshot_t;

	// item kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ARM  = 1'b1;

	// bits of timers_present
	localparam int TMR_PERIOD = 0;
	localparam int TMR_DELAY  = 1;
	localparam int TMR_SPAN   = 2;

	// reset values of the registers
	localparam logic [TIME_W-1:0]  RST_PERIOD_TICKS      = 32'd3000;
	localparam logic [TIME_W-1:0]  RST_START_DELAY_TICKS = 32'd3000;
	localparam logic [TIME_W-1:0]  RST_DURATION_TICKS    = 32'd3000;
	localparam logic [LIMIT_W-1:0] RST_REPEAT_LIMIT      = 16'd0;
	localparam logic               RST_COUNT_PAST_LIMIT  = 1'b0;
	localparam logic [2:0]         RST_ONESHOT_MODE      = 3'd6;
	localparam logic [2:0]         RST_TIMERS_PRESENT    = 3'd1;
	localparam logic               RST_TASK_ENABLED      = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  period_ticks;
		logic [TIME_W-1:0]  start_delay_ticks;
		logic [TIME_W-1:0]  duration_ticks;
		logic [LIMIT_W-1:0] repeat_limit;
		logic               count_past_limit;
		logic [2:0]         oneshot_mode;
		logic [2:0]         timers_present;
		logic               task_enabled;
	} cfg_t;

	typedef struct packed {
		logic end_ev;
		logic run_ev;
		logic start_ev;
	} ev_t;

endpackage

[design/drt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// drt_cfg_regs
// Configuration register file, written one word at a time.
// ----------------------------------------------------------------------------
module drt_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [drt_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]     wr_data,
	output drt_pkg::cfg_t                      cfg
);

	drt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks      <= drt_pkg::RST_PERIOD_TICKS;
			cfg_q.start_delay_ticks <= drt_pkg::RST_START_DELAY_TICKS;
			cfg_q.duration_ticks    <= drt_pkg::RST_DURATION_TICKS;
			cfg_q.repeat_limit      <= drt_pkg::RST_REPEAT_LIMIT;
			cfg_q.count_past_limit  <= drt_pkg::RST_COUNT_PAST_LIMIT;
			cfg_q.oneshot_mode      <= drt_pkg::RST_ONESHOT_MODE;
			cfg_q.timers_present    <= drt_pkg::RST_TIMERS_PRESENT;
			cfg_q.task_enabled      <= drt_pkg::RST_TASK_ENABLED;
		end else if (wr_en) begin
			case (drt_pkg::cfg_idx_t'(wr_index))
				drt_pkg::CFG_PERIOD_TICKS:      cfg_q.period_ticks      <= wr_data;
				drt_pkg::CFG_START_DELAY_TICKS: cfg_q.start_delay_ticks <= wr_data;
				drt_pkg::CFG_DURATION_TICKS:    cfg_q.duration_ticks    <= wr_data;
				drt_pkg::CFG_REPEAT_LIMIT:
					cfg_q.repeat_limit <= wr_data[drt_pkg::LIMIT_W-1:0];
				drt_pkg::CFG_COUNT_PAST_LIMIT:  cfg_q.count_past_limit  <= wr_data[0];
				drt_pkg::CFG_ONESHOT_MODE:      cfg_q.oneshot_mode      <= wr_data[2:0];
				drt_pkg::CFG_TIMERS_PRESENT:    cfg_q.timers_present    <= wr_data[2:0];
				drt_pkg::CFG_TASK_ENABLED:      cfg_q.task_enabled      <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/drt_elapsed.sv]
// ----------------------------------------------------------------------------
// drt_elapsed
// Wrapped elapsed-time compare: flags a timer whose length has gone by.
// ----------------------------------------------------------------------------
module drt_elapsed (
	input  logic [drt_pkg::TIME_W-1:0] now_time,
	input  logic [drt_pkg::TIME_W-1:0] mark,
	input  logic [drt_pkg::TIME_W-1:0] length,
	output logic                       expired
);

	logic [drt_pkg::TIME_W:0]   diff;
	logic [drt_pkg::TIME_W-1:0] span;

	// behind the mark the count wraps through all-ones, one short of a full turn
	always_comb begin
		diff    = {1'b0, now_time} - {1'b0, mark};
		span    = diff[drt_pkg::TIME_W-1:0] - {{(drt_pkg::TIME_W-1){1'b0}}, diff[drt_pkg::TIME_W]};
		expired = (span >= length);
	end

endmodule

[design/drt_core.sv]
// ----------------------------------------------------------------------------
// drt_core
// Timer state and the single-pass step logic for one word.
// ----------------------------------------------------------------------------
module drt_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  drt_pkg::cfg_t              cfg,
	input  logic                       step,
	input  logic                       op,
	input  logic [drt_pkg::TIME_W-1:0] now_time,
	input  logic                       start_flag,
	output drt_pkg::ev_t               ev,
	output logic                       delay_spent
);

	logic                        period_on_q, delay_on_q, delay_spent_q, span_on_q;
	logic [drt_pkg::TIME_W-1:0]  period_mark_q, delay_mark_q, span_mark_q;
	logic [drt_pkg::COUNT_W-1:0] repeat_count_q;

	logic                        period_on_d, delay_spent_d, span_on_d;
	logic [drt_pkg::TIME_W-1:0]  period_mark_d, delay_mark_d, span_mark_d;
	logic [drt_pkg::COUNT_W-1:0] repeat_count_d;

	logic delay_exp, span_exp, period_exp;

	drt_elapsed u_delay (
		.now_time (now_time),
		.mark     (delay_mark_q),
		.length   (cfg.start_delay_ticks),
		.expired  (delay_exp)
	);

	drt_elapsed u_span (
		.now_time (now_time),
		.mark     (span_mark_q),
		.length   (cfg.duration_ticks),
		.expired  (span_exp)
	);

	drt_elapsed u_period (
		.now_time (now_time),
		.mark     (period_mark_q),
		.length   (cfg.period_ticks),
		.expired  (period_exp)
	);

	always_comb begin
		logic                        has_period, has_delay, has_span, oneshot;
		logic                        is_tick, delay_hit, do_arm, go;
		logic                        span_new, period_new, span_hit, period_hit, stop;
		logic [drt_pkg::COUNT_W-1:0] count_inc, limit_ext;

		has_period = cfg.timers_present[drt_pkg::TMR_PERIOD];
		has_delay  = cfg.timers_present[drt_pkg::TMR_DELAY];
		has_span   = cfg.timers_present[drt_pkg::TMR_SPAN];
		oneshot    = (cfg.repeat_limit == '0);

		is_tick   = (op == drt_pkg::OP_TICK) && cfg.task_enabled;
		delay_hit = has_delay && !delay_spent_q && delay_on_q && delay_exp;
		if (op == drt_pkg::OP_ARM) begin
			do_arm = !(has_delay && !delay_spent_q);
			go     = start_flag;
		end else begin
			do_arm = is_tick && delay_hit;
			go     = 1'b1;
		end

		period_on_d    = period_on_q;
		period_mark_d  = period_mark_q;
		delay_spent_d  = delay_spent_q;
		delay_mark_d   = delay_mark_q;
		span_on_d      = span_on_q;
		span_mark_d    = span_mark_q;
		repeat_count_d = repeat_count_q;
		ev             = '0;

		// start delay expiry arms once
		if (do_arm && is_tick) begin
			delay_mark_d  = now_time;
			delay_spent_d = 1'b1;
		end

		if (do_arm) begin
			if (oneshot) begin
				if (go) begin
					case (drt_pkg::oneshot_t'(cfg.oneshot_mode))
						drt_pkg::OS_START: ev.start_ev = 1'b1;
						drt_pkg::OS_RUN:   ev.run_ev = 1'b1;
						drt_pkg::OS_START_RUN: begin
							ev.start_ev = 1'b1;
							ev.run_ev   = 1'b1;
						end
						drt_pkg::OS_START_RUN_END: begin
							ev.start_ev = 1'b1;
							ev.run_ev   = 1'b1;
							ev.end_ev   = 1'b1;
						end
						drt_pkg::OS_START_END: begin
							ev.start_ev = 1'b1;
							ev.end_ev   = 1'b1;
						end
						drt_pkg::OS_RUN_END: begin
							ev.run_ev = 1'b1;
							ev.end_ev = 1'b1;
						end
						default: ;
					endcase
					if (has_period) begin
						period_on_d = 1'b0;
					end
				end
			end else begin
				ev.start_ev = 1'b1;
				if (has_period) begin
					period_on_d   = go;
					period_mark_d = now_time;
				end
				if (has_span) begin
					span_on_d   = go;
					span_mark_d = now_time;
				end
			end
		end

		// a mark just moved to now leaves zero elapsed
		span_new   = do_arm && !oneshot && has_span;
		period_new = do_arm && !oneshot && has_period;
		span_hit   = 1'b0;
		period_hit = 1'b0;
		stop       = 1'b0;
		limit_ext  = {1'b0, cfg.repeat_limit};
		count_inc  = repeat_count_q + 1'b1;

		if (is_tick && has_period && period_on_d) begin
			span_hit = has_span && span_on_d &&
				(span_new ? (cfg.duration_ticks == '0) : span_exp);
			if (span_hit) begin
				span_mark_d = now_time;
				period_on_d = 1'b0;
				span_on_d   = 1'b0;
				ev.end_ev   = 1'b1;
			end
			period_hit = period_on_d &&
				(period_new ? (cfg.period_ticks == '0) : period_exp);
			if (period_hit) begin
				period_mark_d = now_time;
				if (!oneshot) begin
					stop = cfg.count_past_limit ? (count_inc > limit_ext)
						: (count_inc >= limit_ext);
					if (stop) begin
						repeat_count_d = '0;
						period_on_d    = 1'b0;
						ev.end_ev      = 1'b1;
						if (!cfg.count_past_limit) begin
							ev.run_ev = 1'b1;
						end
					end else begin
						repeat_count_d = count_inc;
						ev.run_ev      = 1'b1;
					end
				end else begin
					ev.run_ev = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_on_q    <= 1'b1;
			period_mark_q  <= '0;
			delay_on_q     <= 1'b1;
			delay_mark_q   <= '0;
			delay_spent_q  <= 1'b0;
			span_on_q      <= 1'b1;
			span_mark_q    <= '0;
			repeat_count_q <= '0;
		end else if (step) begin
			period_on_q    <= period_on_d;
			period_mark_q  <= period_mark_d;
			delay_on_q     <= delay_on_q;
			delay_mark_q   <= delay_mark_d;
			delay_spent_q  <= delay_spent_d;
			span_on_q      <= span_on_d;
			span_mark_q    <= span_mark_d;
			repeat_count_q <= repeat_count_d;
		end
	end

	assign delay_spent = delay_spent_q;

endmodule

[design/delayed_repeat_timer_controller_top.sv]
// ----------------------------------------------------------------------------
// delayed_repeat_timer_controller_top
// Start delay, periodic and duration timers driven by a stream of time ticks
// and arm commands; one event word out for every word in.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                       | Direction | Word
//   --------+-------------------------------+-----------+---------------------------
//   s_      | s_tvalid s_tready s_tdata/user | in        | tick or arm command
//   m_      | m_tvalid m_tready m_tdata      | out       | start, run, end events
//   cfg_    | cfg_valid cfg_ready idx/data   | in        | register write
//
// Each word passes from acceptance to its result through the input register,
// where the whole step (three wrapped elapsed compares and the next state) is
// worked out, and then the result register. A new word is taken every cycle
// while results drain. Reset puts the timers and registers at their defaults
// at once; there is no clearing pass. A stalled result register holds the input
// register, and with it the timer state, until the result is taken.
// cfg_ready is always high; write registers only while the block is idle.
module delayed_repeat_timer_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,  // [31:0] now_time, [32] start_flag
	input  logic [0:0]                        s_tuser,  // [0] op
	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [0] start, [1] run, [2] end
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	drt_pkg::cfg_t               cfg;
	drt_pkg::ev_t                ev;
	logic                        delay_spent;

	logic                        valid_s1;
	logic                        op_s1;
	logic [drt_pkg::TIME_W-1:0]  now_s1;
	logic                        flag_s1;

	logic                        out_valid_q;
	drt_pkg::ev_t                ev_q;

	logic                        advance;

	// move the staged word on when the result register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	drt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register: hold the word while the result side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[0];
			now_s1  <= s_tdata[drt_pkg::TIME_W-1:0];
			flag_s1 <= s_tdata[drt_pkg::TIME_W];
		end
	end

	// timer state commits only as the word's result is registered
	drt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (advance),
		.op          (op_s1),
		.now_time    (now_s1),
		.start_flag  (flag_s1),
		.ev          (ev),
		.delay_spent (delay_spent)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q <= ev;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, ev_q.end_ev, ev_q.run_ev, ev_q.start_ev};

	// a staged word never vanishes without moving on
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("staged word dropped while stalled");

	// a result appears only from a staged word
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result raised without a staged word");

	// the start delay fires once and stays spent
	a_delay_once: assert property (@(posedge clk) disable iff (!arst_n)
		delay_spent |=> delay_spent)
		else $error("start delay came back after firing");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the delayed repeat timer controller: tick and arm
// words go in, each event word coming out is compared with a timer model.
// ----------------------------------------------------------------------------
module tb_top;
	import drt_pkg::*;

	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_TICKS = 4;     // result path is two deep; allow a bit more
	localparam int PHASES       = 14;
	localparam int PHASE_WORDS  = 85;
	localparam int HOLD_CYCLES  = 160;

	// ------------------------------------------------------------------------
	// Timer model and the queue of event words still owed by the block.
	// take_word runs on every accepted input word, match_events on every
	// accepted output word.
	// ------------------------------------------------------------------------
	class event_tracker;
		cfg_t              regs;
		logic              period_on, delay_on, delay_spent, span_on;
		logic [TIME_W-1:0] period_mark, delay_mark, span_mark;
		logic [COUNT_W-1:0] repeat_count;
		ev_t               events_due[$];
		int                n_words, n_arms, n_checked, n_bad;
		int                n_start, n_run, n_end;

		function new();
			regs.period_ticks      = RST_PERIOD_TICKS;
			regs.start_delay_ticks = RST_START_DELAY_TICKS;
			regs.duration_ticks    = RST_DURATION_TICKS;
			regs.repeat_limit      = RST_REPEAT_LIMIT;
			regs.count_past_limit  = RST_COUNT_PAST_LIMIT;
			regs.oneshot_mode      = RST_ONESHOT_MODE;
			regs.timers_present    = RST_TIMERS_PRESENT;
			regs.task_enabled      = RST_TASK_ENABLED;
			period_on    = 1'b1;
			period_mark  = '0;
			delay_on     = 1'b1;
			delay_mark   = '0;
			delay_spent  = 1'b0;
			span_on      = 1'b1;
			span_mark    = '0;
			repeat_count = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_PERIOD_TICKS:      regs.period_ticks      = v;
				CFG_START_DELAY_TICKS: regs.start_delay_ticks = v;
				CFG_DURATION_TICKS:    regs.duration_ticks    = v;
				CFG_REPEAT_LIMIT:      regs.repeat_limit      = v[LIMIT_W-1:0];
				CFG_COUNT_PAST_LIMIT:  regs.count_past_limit  = v[0];
				CFG_ONESHOT_MODE:      regs.oneshot_mode      = v[2:0];
				CFG_TIMERS_PRESENT:    regs.timers_present    = v[2:0];
				CFG_TASK_ENABLED:      regs.task_enabled      = v[0];
				default: ;
			endcase
		endfunction

		// elapsed time with the block's wrap rule (one short of modulo on wrap)
		function logic [TIME_W-1:0] since(logic [TIME_W-1:0] now, logic [TIME_W-1:0] mark);
			if (now >= mark)
				return now - mark;
			return (TIME_TOP - mark) + now;
		endfunction

		function void fire_arm(logic [TIME_W-1:0] now, logic go, inout ev_t ev);
			if (regs.repeat_limit == '0) begin
				// one-shot: raise the selected events, park the periodic timer
				if (!go)
					return;
				case (regs.oneshot_mode)
					OS_START:         ev.start_ev = 1'b1;
					OS_RUN:           ev.run_ev = 1'b1;
					OS_START_RUN:     begin ev.start_ev = 1'b1; ev.run_ev = 1'b1; end
					OS_START_RUN_END: begin
						ev.start_ev = 1'b1;
						ev.run_ev = 1'b1;
						ev.end_ev = 1'b1;
					end
					OS_START_END:     begin ev.start_ev = 1'b1; ev.end_ev = 1'b1; end
					OS_RUN_END:       begin ev.run_ev = 1'b1; ev.end_ev = 1'b1; end
					default: ;
				endcase
				if (regs.timers_present[TMR_PERIOD])
					period_on = 1'b0;
			end else begin
				ev.start_ev = 1'b1;
				if (regs.timers_present[TMR_PERIOD]) begin
					period_on   = go;
					period_mark = now;
				end
				if (regs.timers_present[TMR_SPAN]) begin
					span_on   = go;
					span_mark = now;
				end
			end
		endfunction

		function void step_timers(logic [TIME_W-1:0] now, inout ev_t ev);
			logic stop;
			if (regs.timers_present[TMR_DELAY] && !delay_spent && delay_on &&
			    since(now, delay_mark) >= regs.start_delay_ticks) begin
				delay_mark  = now;
				delay_spent = 1'b1;
				fire_arm(now, 1'b1, ev);
			end
			if (!regs.timers_present[TMR_PERIOD] || !period_on)
				return;
			// duration expiry wins over a period expiry on the same tick
			if (regs.timers_present[TMR_SPAN] && span_on &&
			    since(now, span_mark) >= regs.duration_ticks) begin
				span_mark  = now;
				period_on  = 1'b0;
				span_on    = 1'b0;
				ev.end_ev  = 1'b1;
			end
			if (period_on && since(now, period_mark) >= regs.period_ticks) begin
				period_mark = now;
				if (regs.repeat_limit != '0) begin
					repeat_count = repeat_count + 1'b1;
					if (regs.count_past_limit)
						stop = repeat_count > {1'b0, regs.repeat_limit};
					else
						stop = repeat_count >= {1'b0, regs.repeat_limit};
					if (stop) begin
						repeat_count = '0;
						period_on    = 1'b0;
						if (!regs.count_past_limit)
							ev.run_ev = 1'b1;
						ev.end_ev = 1'b1;
					end else begin
						ev.run_ev = 1'b1;
					end
				end else begin
					ev.run_ev = 1'b1;
				end
			end
		endfunction

		function void take_word(logic op, logic [TIME_W-1:0] now, logic go);
			ev_t ev;
			ev = '0;
			n_words++;
			if (op == OP_ARM) begin
				n_arms++;
				// an unspent start delay owns arming
				if (!(regs.timers_present[TMR_DELAY] && !delay_spent))
					fire_arm(now, go, ev);
			end else if (regs.task_enabled) begin
				step_timers(now, ev);
			end
			n_start += int'(ev.start_ev);
			n_run   += int'(ev.run_ev);
			n_end   += int'(ev.end_ev);
			events_due.push_back(ev);
		endfunction

		function void compare_field(string name, logic [4:0] want, logic [4:0] got);
			if (got !== want) begin
				n_bad++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void match_events(logic [7:0] word);
			ev_t want;
			if (events_due.size() == 0) begin
				n_bad++;
				$display("%0t: event word %0h with none expected, expected nothing actual %0h",
				         $time, word, word);
				return;
			end
			want = events_due.pop_front();
			n_checked++;
			compare_field("start", {4'd0, want.start_ev}, {4'd0, word[0]});
			compare_field("run",   {4'd0, want.run_ev},   {4'd0, word[1]});
			compare_field("end",   {4'd0, want.end_ev},   {4'd0, word[2]});
			compare_field("pad",   5'd0,                  word[7:3]);
		endfunction

		function int pending();
			return events_due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [39:0]           s_tdata;    // [31:0] now_time, [32] start_flag
	logic [0:0]            s_tuser;    // [0] op
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;    // [0] start, [1] run, [2] end
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	delayed_repeat_timer_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	event_tracker      tracker = new();
	logic              gaps_on;       // sender inserts idle bursts
	logic              stalls_on;     // receiver inserts stall bursts
	int                hold_cycles;   // one-off long receiver hold, picked up by the sink
	int                cycle_count;
	int                n_settings;
	logic [TIME_W-1:0] clock_now;     // running time stamp for well-formed ticks

	// 8 ns clock
	initial begin : clock_gen
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor both streams at the rising edge. Drain results before taking
	// the new word so a result never consumes an expectation from its own edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.match_events(m_tdata);
			if (s_tvalid && s_tready)
				tracker.take_word(s_tuser[0], s_tdata[TIME_W-1:0], s_tdata[TIME_W]);
		end
	end

	// Result sink: ready by default, random stall bursts, and a long hold
	// when the stimulus asks for one so the block backs up into its input.
	initial begin : result_sink
		int low_for;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				low_for = hold_cycles;
				hold_cycles = 0;
				m_tready <= 1'b0;
				repeat (low_for - 1) @(negedge clk);
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run stuck after %0d cycles, %0d event words still due",
		         $time, CYCLE_LIMIT, tracker.pending());
		$display("tb_top failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers. All of them are entered and left at a falling edge.
	// ------------------------------------------------------------------------

	// Offer one word, maybe after an idle burst; hold it until taken.
	task automatic send_word(input logic op, input logic [TIME_W-1:0] now, input logic go);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, go, now};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed event word has come back,
	// then let the pipeline go quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, v);
		@(negedge clk);
	endtask

	// Write every register; only called with the block drained.
	task automatic configure(input cfg_t c);
		drain();
		write_reg(CFG_PERIOD_TICKS,      c.period_ticks);
		write_reg(CFG_START_DELAY_TICKS, c.start_delay_ticks);
		write_reg(CFG_DURATION_TICKS,    c.duration_ticks);
		write_reg(CFG_REPEAT_LIMIT,      {16'd0, c.repeat_limit});
		write_reg(CFG_COUNT_PAST_LIMIT,  {31'd0, c.count_past_limit});
		write_reg(CFG_ONESHOT_MODE,      {29'd0, c.oneshot_mode});
		write_reg(CFG_TIMERS_PRESENT,    {29'd0, c.timers_present});
		write_reg(CFG_TASK_ENABLED,      {31'd0, c.task_enabled});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic cfg_t make_cfg(logic [TIME_W-1:0] period, logic [TIME_W-1:0] delay,
	                                  logic [TIME_W-1:0] dur, logic [LIMIT_W-1:0] limit,
	                                  logic past, logic [2:0] mode, logic [2:0] present,
	                                  logic enabled);
		cfg_t c;
		c.period_ticks      = period;
		c.start_delay_ticks = delay;
		c.duration_ticks    = dur;
		c.repeat_limit      = limit;
		c.count_past_limit  = past;
		c.oneshot_mode      = mode;
		c.timers_present    = present;
		c.task_enabled      = enabled;
		return c;
	endfunction

	// Short periods and durations so that run and end events come often.
	function automatic cfg_t random_cfg();
		cfg_t c;
		case ($urandom_range(0, 9))
			0:       c.period_ticks = '0;
			1:       c.period_ticks = TIME_TOP;
			2:       c.period_ticks = $urandom;
			default: c.period_ticks = $urandom_range(1, 16);
		endcase
		c.start_delay_ticks = $urandom;
		case ($urandom_range(0, 7))
			0:       c.duration_ticks = '0;
			1:       c.duration_ticks = $urandom_range(200, 5000);
			default: c.duration_ticks = $urandom_range(5, 120);
		endcase
		case ($urandom_range(0, 7))
			0, 1:    c.repeat_limit = '0;
			2:       c.repeat_limit = '1;
			default: c.repeat_limit = LIMIT_W'($urandom_range(1, 6));
		endcase
		c.count_past_limit = 1'($urandom_range(0, 1));
		c.oneshot_mode     = 3'($urandom_range(0, 7));
		c.timers_present   = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 3) != 0)
			c.timers_present[TMR_PERIOD] = 1'b1;
		c.task_enabled = ($urandom_range(0, 6) != 0);
		return c;
	endfunction

	// Mostly forward-moving ticks with an arm now and then; a slice of
	// arbitrary time stamps and kinds as noise.
	task automatic run_phase(input int n_words, input logic long_hold, input logic pause);
		int i;
		int pick;
		logic [TIME_W-1:0] t;
		if ($urandom_range(0, 3) == 0)
			clock_now = TIME_TOP - $urandom_range(0, 60);   // wrap soon
		send_word(OP_ARM, clock_now, 1'b1);
		for (i = 0; i < n_words; i++) begin
			if (long_hold && i == n_words / 2)
				hold_cycles = HOLD_CYCLES;
			if (pause && i == n_words / 3)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_word(OP_ARM, clock_now, $urandom_range(0, 4) != 0);
			end else if (pick < 14) begin
				t = $urandom;
				if ($urandom_range(0, 1))
					clock_now = t;
				send_word(1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1)));
			end else begin
				if ($urandom_range(0, 19) == 0)
					clock_now += $urandom_range(0, 5000);
				else
					clock_now += $urandom_range(0, 6);
				send_word(OP_TICK, clock_now, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		cfg_t c;
		int p;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_TICK;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_PERIOD_TICKS;
		cfg_data    = '0;
		gaps_on     = 1'b0;
		stalls_on   = 1'b0;
		hold_cycles = 0;
		n_settings  = 0;
		clock_now   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;

		// Defaults: periodic timer alone, one-shot with no events selected.
		send_word(OP_TICK, 32'd0, 1'b0);
		send_word(OP_TICK, 32'd2999, 1'b0);
		send_word(OP_TICK, 32'd3000, 1'b0);        // first period expiry
		send_word(OP_ARM,  32'd3000, 1'b1);        // one-shot, nothing raised, period parked
		send_word(OP_TICK, 32'd6000, 1'b0);

		// All three timers, start delay still pending.
		configure(make_cfg(32'd5, 32'd20, 32'd12, 16'd3, 1'b0, OS_START_RUN_END, 3'b111, 1'b1));
		send_word(OP_ARM,  32'd10, 1'b1);          // ignored: delay owns arming
		send_word(OP_TICK, 32'd10, 1'b0);
		send_word(OP_TICK, 32'd20, 1'b0);          // delay fires and arms
		send_word(OP_TICK, 32'd25, 1'b0);
		send_word(OP_TICK, 32'd30, 1'b0);
		send_word(OP_TICK, 32'd35, 1'b0);          // duration and period together
		send_word(OP_ARM,  32'd40, 1'b1);
		send_word(OP_TICK, 32'd45, 1'b0);          // repeat limit reached
		send_word(OP_ARM,  32'd50, 1'b0);          // arm, timers left stopped
		send_word(OP_TICK, 32'd60, 1'b0);

		// One-shot arms with the task disabled.
		configure(make_cfg(32'd5, 32'd20, 32'd12, 16'd0, 1'b0, OS_RUN_END, 3'b111, 1'b0));
		send_word(OP_ARM,  32'd70, 1'b0);          // no start flag: no change
		send_word(OP_ARM,  32'd70, 1'b1);
		send_word(OP_TICK, 32'd80, 1'b1);          // ignored while disabled

		// Zero period, count past the limit, periodic timer alone.
		configure(make_cfg(32'd0, 32'd20, 32'd12, 16'd2, 1'b1, 3'd7, 3'b001, 1'b1));
		send_word(OP_ARM,  32'd100, 1'b1);
		send_word(OP_TICK, 32'd100, 1'b0);
		send_word(OP_TICK, 32'd100, 1'b0);
		send_word(OP_TICK, 32'd100, 1'b0);         // past the limit: end without run

		// Unused one-shot selection behaves as none.
		configure(make_cfg(32'd0, 32'd20, 32'd12, 16'd0, 1'b1, 3'd7, 3'b001, 1'b1));
		send_word(OP_ARM,  32'd100, 1'b1);
		clock_now = 32'd100;

		// Random phases: register extremes first, last phase without idling.
		for (p = 0; p < PHASES; p++) begin
			if (p == 0)
				c = make_cfg('0, '0, '0, 16'd1, 1'b0, OS_START, 3'b111, 1'b1);
			else if (p == 1)
				c = make_cfg(TIME_TOP, TIME_TOP, TIME_TOP, '1, 1'b1, 3'd7, 3'b111, 1'b1);
			else
				c = random_cfg();
			configure(c);
			if (p == PHASES - 1) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on   = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			run_phase(PHASE_WORDS, p == 3 || p == 9, p == 5);
		end

		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d words (%0d arm commands) over %0d register settings",
		         tracker.n_words, tracker.n_arms, n_settings);
		$display("checked %0d event words: %0d start, %0d run, %0d end raised",
		         tracker.n_checked, tracker.n_start, tracker.n_run, tracker.n_end);
		if (tracker.n_bad == 0 && tracker.pending() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches, %0d event words never arrived",
			         tracker.n_bad, tracker.pending());
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
